// ===== hdl/avtsa_pkg.sv =====
`default_nettype none

package avtsa_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_AUDIO_WINDOW     = 2'd0;
    localparam logic [1:0] CFG_VIDEO_JUMP_LIMIT = 2'd1;
    localparam logic [1:0] CFG_FILL_DELAY       = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] RST_AUDIO_WINDOW     = 16'd3000;
    localparam logic [15:0] RST_VIDEO_JUMP_LIMIT = 16'd10000;
    localparam logic [15:0] RST_FILL_DELAY       = 16'd2000;

    // Input item kinds.
    localparam logic OP_AUDIO = 1'b0;
    localparam logic OP_VIDEO = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_AUDIO = 2'd0;
    localparam logic [1:0] KIND_VIDEO = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;
    localparam logic [1:0] KIND_DROP  = 2'd3;

    // Filler audio constants.
    localparam logic [63:0] FILL_MARGIN = 64'd1000;
    localparam logic [63:0] FILL_STEP   = 64'd128;
    localparam logic [3:0]  MAX_FILL    = 4'd8;

    typedef struct packed {
        logic               opcode;
        logic signed [63:0] stamp;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [63:0] out_stamp;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic [15:0] audio_window;
        logic [15:0] video_jump_limit;
        logic [15:0] fill_delay;
    } t_cfg;

    // Word handed from the front queue to the back sequencer.
    typedef struct packed {
        logic        is_video;
        logic [63:0] stamp;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_DIFF,
        ST_A_OFS,
        ST_A_CORR,
        ST_A_GAP,
        ST_A_PUT,
        ST_V_DIFF,
        ST_V_JUMP,
        ST_V_USED,
        ST_V_SEEN,
        ST_V_LAG,
        ST_V_FGAP,
        ST_V_FSET,
        ST_V_FILL,
        ST_V_PUT
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/avtsa_front.sv =====
`default_nettype none

module avtsa_front
    import avtsa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_word i_word,
    output logic          o_stall,
    output logic          o_item_valid,
    output t_item         o_item,
    input  wire logic     i_pop
);

    // Two-entry queue of classified words.
    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_stall      = (r_count == 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_push       = i_valid && !o_stall;
    assign w_pop        = i_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr].is_video <= (i_word.opcode == OP_VIDEO);
            r_mem[r_wr_ptr].stamp    <= i_word.stamp;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/avtsa_back.sv =====
`default_nettype none

module avtsa_back
    import avtsa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_item_valid,
    input  wire t_item    i_item,
    output logic          o_pop,
    output logic          o_valid,
    output t_out_word     o_word,
    input  wire logic     i_stall
);

    t_state      r_state, n_state;
    logic [63:0] r_stamp, n_stamp;
    logic [63:0] r_diff, n_diff;
    logic [63:0] r_corr, n_corr;
    logic [63:0] r_used, n_used;
    logic [3:0]  r_cnt, n_cnt;

    logic        r_align_ready, n_align_ready;
    logic        r_raw_valid, n_raw_valid;
    logic        r_used_valid, n_used_valid;
    logic [63:0] r_raw_prev, n_raw_prev;
    logic [63:0] r_used_prev, n_used_prev;
    logic [63:0] r_video_ofs, n_video_ofs;
    logic [63:0] r_audio_ofs, n_audio_ofs;
    logic [63:0] r_audio_seen, n_audio_seen;
    logic [63:0] r_video_seen, n_video_seen;
    logic [63:0] r_filler, n_filler;

    logic        r_out_valid, n_out_valid;
    t_out_word   r_out, n_out;

    logic        w_can_put;
    logic [63:0] w_mag;
    logic [63:0] w_win;
    logic [63:0] w_jump;
    logic [63:0] w_delay;
    logic [63:0] w_delay_m;
    logic        w_drop;

    assign w_can_put = !r_out_valid || !i_stall;
    assign w_mag     = r_diff[63] ? (64'd0 - r_diff) : r_diff;
    assign w_win     = {48'd0, i_cfg.audio_window};
    assign w_jump    = {48'd0, i_cfg.video_jump_limit};
    assign w_delay   = {48'd0, i_cfg.fill_delay};
    assign w_delay_m = w_delay - FILL_MARGIN;
    assign w_drop    = r_used_valid && (w_mag > w_win);

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_comb begin
        n_state       = r_state;
        n_stamp       = r_stamp;
        n_diff        = r_diff;
        n_corr        = r_corr;
        n_used        = r_used;
        n_cnt         = r_cnt;
        n_align_ready = r_align_ready;
        n_raw_valid   = r_raw_valid;
        n_used_valid  = r_used_valid;
        n_raw_prev    = r_raw_prev;
        n_used_prev   = r_used_prev;
        n_video_ofs   = r_video_ofs;
        n_audio_ofs   = r_audio_ofs;
        n_audio_seen  = r_audio_seen;
        n_video_seen  = r_video_seen;
        n_filler      = r_filler;
        n_out         = r_out;
        n_out_valid   = r_out_valid && i_stall;
        o_pop         = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_stamp = i_item.stamp;
                    if (i_item.is_video) begin
                        n_state = ST_V_DIFF;
                    end else if (r_align_ready) begin
                        n_state = ST_A_CORR;
                    end else begin
                        n_state = ST_A_DIFF;
                    end
                end
            end
            ST_A_DIFF: begin
                n_diff  = r_stamp - r_used_prev;
                n_state = ST_A_OFS;
            end
            ST_A_OFS: begin
                n_audio_ofs   = (w_mag > w_win) ? r_diff : 64'd0;
                n_align_ready = 1'b1;
                n_state       = ST_A_CORR;
            end
            ST_A_CORR: begin
                n_corr  = r_stamp - r_audio_ofs;
                n_state = ST_A_GAP;
            end
            ST_A_GAP: begin
                n_diff  = r_corr - r_used_prev;
                n_state = ST_A_PUT;
            end
            ST_A_PUT: begin
                if (w_can_put) begin
                    n_out_valid     = 1'b1;
                    n_out.out_stamp = r_corr;
                    n_out.last      = 1'b1;
                    if (w_drop) begin
                        n_align_ready = 1'b0;
                        n_out.kind    = KIND_DROP;
                    end else begin
                        n_out.kind = KIND_AUDIO;
                        if (i_cfg.fill_delay != 16'd0) begin
                            n_audio_seen = r_corr;
                            if (!($signed(r_corr) < $signed(r_filler))) begin
                                n_filler = r_corr;
                            end
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_V_DIFF: begin
                n_diff  = r_stamp - r_raw_prev;
                n_state = ST_V_JUMP;
            end
            ST_V_JUMP: begin
                if (r_raw_valid && (w_mag > w_jump)) begin
                    n_align_ready = 1'b0;
                    n_video_ofs   = r_video_ofs + r_diff;
                end
                n_raw_prev  = r_stamp;
                n_raw_valid = 1'b1;
                n_state     = ST_V_USED;
            end
            ST_V_USED: begin
                n_used       = r_stamp - r_video_ofs;
                n_used_prev  = r_stamp - r_video_ofs;
                n_video_seen = r_stamp - r_video_ofs;
                n_used_valid = 1'b1;
                n_state      = ST_V_SEEN;
            end
            ST_V_SEEN: begin
                n_diff  = r_used - r_audio_seen;
                n_state = ST_V_LAG;
            end
            ST_V_LAG: begin
                n_state = ($signed(r_diff) > $signed(w_delay)) ? ST_V_FGAP : ST_V_PUT;
            end
            ST_V_FGAP: begin
                n_diff  = r_used - r_filler;
                n_state = ST_V_FSET;
            end
            ST_V_FSET: begin
                // After the filler time is pulled up, video leads it by exactly the delay.
                if ($signed(r_diff) > $signed(w_delay)) begin
                    n_filler = r_used - w_delay;
                    n_diff   = w_delay;
                end
                n_cnt   = 4'd0;
                n_state = ST_V_FILL;
            end
            ST_V_FILL: begin
                if ((r_cnt < MAX_FILL) && ($signed(r_diff) > $signed(w_delay_m))) begin
                    if (w_can_put) begin
                        n_out_valid     = 1'b1;
                        n_out.kind      = KIND_FILL;
                        n_out.out_stamp = r_filler;
                        n_out.last      = 1'b0;
                        n_filler        = r_filler + FILL_STEP;
                        n_diff          = r_diff - FILL_STEP;
                        n_cnt           = r_cnt + 4'd1;
                    end
                end else begin
                    n_state = ST_V_PUT;
                end
            end
            ST_V_PUT: begin
                if (w_can_put) begin
                    n_out_valid     = 1'b1;
                    n_out.kind      = KIND_VIDEO;
                    n_out.out_stamp = r_used;
                    n_out.last      = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_align_ready <= 1'b0;
            r_raw_valid   <= 1'b0;
            r_used_valid  <= 1'b0;
            r_raw_prev    <= '1;
            r_used_prev   <= '1;
            r_video_ofs   <= '0;
            r_audio_ofs   <= '0;
            r_audio_seen  <= '0;
            r_video_seen  <= '0;
            r_filler      <= '0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_align_ready <= n_align_ready;
            r_raw_valid   <= n_raw_valid;
            r_used_valid  <= n_used_valid;
            r_raw_prev    <= n_raw_prev;
            r_used_prev   <= n_used_prev;
            r_video_ofs   <= n_video_ofs;
            r_audio_ofs   <= n_audio_ofs;
            r_audio_seen  <= n_audio_seen;
            r_video_seen  <= n_video_seen;
            r_filler      <= n_filler;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp <= n_stamp;
        r_diff  <= n_diff;
        r_corr  <= n_corr;
        r_used  <= n_used;
        r_cnt   <= n_cnt;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

// ===== hdl/av_timestamp_aligner_with_audio_fill.sv =====
// An audio word steps through A_DIFF and A_OFS (while audio is not aligned), A_CORR, A_GAP
// and A_PUT; a video word through V_DIFF, V_JUMP, V_USED, V_SEEN, V_LAG, then V_FGAP, V_FSET and
// V_FILL when video leads the last audio by more than the fill delay, and V_PUT. Fillers stream at
// one result per cycle while the sink does not stall; the back sequencer takes one word at a time.
// Reset (synchronous, active low) empties the queue and the output register, restores the
// configuration defaults and returns all timing state to its initial values.
`default_nettype none

module av_timestamp_aligner_with_audio_fill
    import avtsa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel: a word is taken when i_valid is high and o_stall is low.
    input  wire logic        i_valid,
    input  wire t_in_word    i_word,
    output logic             o_stall,
    // Output channel: a word is taken when o_valid is high and i_stall is low.
    output logic             o_valid,
    output t_out_word        o_word,
    input  wire logic        i_stall,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    // Configuration registers. Writes to an index past the list are ignored.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.audio_window     <= RST_AUDIO_WINDOW;
            r_cfg.video_jump_limit <= RST_VIDEO_JUMP_LIMIT;
            r_cfg.fill_delay       <= RST_FILL_DELAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AUDIO_WINDOW:     r_cfg.audio_window     <= i_cfg_data;
                CFG_VIDEO_JUMP_LIMIT: r_cfg.video_jump_limit <= i_cfg_data;
                CFG_FILL_DELAY:       r_cfg.fill_delay       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front takes input words into a two-entry queue and tags each as audio or video,
    // so the source can hand over two words while the back is busy; it stalls when both are full.
    logic  w_item_valid;
    t_item w_item;
    logic  w_pop;

    avtsa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_word       (i_word),
        .o_stall      (o_stall),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    // The back steps through one word at a time: one 64-bit subtract or compare per cycle,
    // then one result per cycle into its output register while the sink does not stall. The output
    // register frees as soon as the sink takes its word, so fillers stream with no bubble.
    avtsa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_word       (o_word),
        .i_stall      (i_stall)
    );

endmodule

`default_nettype wire

// ===== hdl/avtsa_checker.sv =====
`default_nettype none

module avtsa_checker
    import avtsa_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_stall,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire t_out_word  o_word
);

    // A waiting result stays offered while the sink stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    // A waiting result keeps its value while the sink stalls.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_word))
        else $error("result word changed while stalled");

    // Only filler words are followed by more results of the same input.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word.last != (o_word.kind == KIND_FILL)))
        else $error("last flag does not match result kind");

    // Reset leaves no result pending and the input side open.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset did not clear the channels");

endmodule

bind av_timestamp_aligner_with_audio_fill avtsa_checker u_avtsa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_stall (i_stall),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_word  (o_word)
);

`default_nettype wire

// ===== tb/sv/av_timestamp_aligner_with_audio_fill_test.sv =====
`timescale 1ns / 100ps

module av_timestamp_aligner_with_audio_fill_test;
    import avtsa_pkg::*;

    // Cycles allowed for the last result to leave the block after the final
    // expected word has been seen. The longest video path puts out eight fillers.
    localparam int SETTLE_CYCLES = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_in_word    i_word = '0;
    logic        o_stall;
    logic        o_valid;
    t_out_word   o_word;
    logic        i_stall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    av_timestamp_aligner_with_audio_fill dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_word     (i_word),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_word     (o_word),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Frames waiting to be offered, and results the aligner must still produce.
    t_in_word  frames_to_send[$];
    t_out_word stamps_due[$];
    int        frames_queued = 0;
    int        frames_taken = 0;
    int        errors = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    logic      word_taken = 1'b0;
    t_out_word seen_word;

    // Our own copy of the aligner's registers and timing state.
    logic [15:0] cfg_window;
    logic [15:0] cfg_jump;
    logic [15:0] cfg_fill;
    logic        align_armed_done;
    logic        raw_seen;
    logic        used_seen;
    logic [63:0] raw_prev;
    logic [63:0] used_prev;
    logic [63:0] video_shift;
    logic [63:0] audio_shift;
    logic [63:0] audio_seen;
    logic [63:0] fill_mark;

    // Stream generator state: where the well-formed video and audio clocks are.
    logic signed [63:0] video_clock;
    logic signed [63:0] audio_clock;
    logic               audio_muted;

    function automatic void reset_aligner_copy();
        cfg_window       = RST_AUDIO_WINDOW;
        cfg_jump         = RST_VIDEO_JUMP_LIMIT;
        cfg_fill         = RST_FILL_DELAY;
        align_armed_done = 1'b0;
        raw_seen         = 1'b0;
        used_seen        = 1'b0;
        raw_prev         = '1;
        used_prev        = '1;
        video_shift      = '0;
        audio_shift      = '0;
        audio_seen       = '0;
        fill_mark        = '0;
    endfunction

    // Gap size as an unsigned value, so the most negative difference counts as 2^63.
    function automatic logic [63:0] gap_size(input logic [63:0] d);
        return d[63] ? 64'd0 - d : d;
    endfunction

    function automatic void expect_stamp(input logic [1:0] kind, input logic [63:0] stamp,
                                         input logic last);
        t_out_word r;
        r.kind      = kind;
        r.out_stamp = stamp;
        r.last      = last;
        stamps_due.push_back(r);
    endfunction

    // Works out every result one accepted frame causes and updates the state copy.
    function automatic void align_and_fill(input t_in_word w);
        logic [63:0]        d;
        logic [63:0]        corr;
        logic [63:0]        used;
        logic signed [63:0] lead;
        logic signed [63:0] delay;
        logic signed [63:0] fill_floor;
        int                 n;
        n = 0;
        if (w.opcode == OP_AUDIO) begin
            // The first audio after arming measures its offset against video.
            if (!align_armed_done) begin
                d = w.stamp - used_prev;
                audio_shift = (gap_size(d) > {48'd0, cfg_window}) ? d : 64'd0;
                align_armed_done = 1'b1;
            end
            corr = w.stamp - audio_shift;
            if (used_seen && gap_size(corr - used_prev) > {48'd0, cfg_window}) begin
                align_armed_done = 1'b0;
                expect_stamp(KIND_DROP, corr, 1'b1);
            end else begin
                // A zero fill delay freezes audio tracking altogether.
                if (cfg_fill != 16'd0) begin
                    audio_seen = corr;
                    if (!($signed(corr) < $signed(fill_mark)))
                        fill_mark = corr;
                end
                expect_stamp(KIND_AUDIO, corr, 1'b1);
            end
        end else begin
            d = w.stamp - raw_prev;
            if (raw_seen && gap_size(d) > {48'd0, cfg_jump}) begin
                align_armed_done = 1'b0;
                video_shift = video_shift + d;
            end
            raw_prev  = w.stamp;
            raw_seen  = 1'b1;
            used      = w.stamp - video_shift;
            used_prev = used;
            used_seen = 1'b1;
            delay      = {48'd0, cfg_fill};
            fill_floor = {48'd0, cfg_fill} - FILL_MARGIN;
            lead = used - audio_seen;
            if (lead > delay) begin
                lead = used - fill_mark;
                if (lead > delay)
                    fill_mark = used - {48'd0, cfg_fill};
                lead = used - fill_mark;
                while (n < MAX_FILL && lead > fill_floor) begin
                    expect_stamp(KIND_FILL, fill_mark, 1'b0);
                    fill_mark = fill_mark + FILL_STEP;
                    n++;
                    lead = used - fill_mark;
                end
            end
            expect_stamp(KIND_VIDEO, used, 1'b1);
        end
    endfunction

    // Driver: offers the next frame once the current one is taken, and drives the
    // receiver's stall. Everything changes at the falling edge only.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            if (!i_valid || word_taken) begin
                if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_word  <= frames_to_send.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: at each rising edge it predicts from the word taken on the input
    // and checks the word taken on the output against the oldest expectation.
    always @(posedge i_clk) begin
        word_taken = i_rst_n && i_valid && !o_stall;
        if (word_taken) begin
            align_and_fill(i_word);
            frames_taken++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (stamps_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, got kind %0d stamp %0d last %0b",
                         $time, o_word.kind, o_word.out_stamp, o_word.last);
            end else begin
                seen_word = stamps_due.pop_front();
                if (o_word !== seen_word) begin
                    errors++;
                    $display("%0t: expected kind %0d stamp %0d last %0b, got kind %0d stamp %0d last %0b",
                             $time, seen_word.kind, seen_word.out_stamp, seen_word.last,
                             o_word.kind, o_word.out_stamp, o_word.last);
                end
            end
        end
    end

    task automatic queue_frame(input logic op, input logic [63:0] stamp);
        t_in_word w;
        w.opcode = op;
        w.stamp  = stamp;
        frames_to_send.push_back(w);
        frames_queued++;
    endtask

    // Mostly a plausible interleave of audio and video with random content;
    // the rest is noise, out-of-window audio, joint jumps and long video strides.
    task automatic queue_stream(input int count);
        int                 r;
        logic signed [63:0] delta;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 6) begin
                queue_frame(1'($urandom_range(1)), {$urandom, $urandom});
            end else if (r < 11) begin
                // Both streams jump together, sometimes to an arbitrary base.
                if (r < 7) begin
                    video_clock = {$urandom, $urandom};
                end else begin
                    delta = $urandom_range(200000, 9000);
                    if ($urandom_range(1))
                        delta = -delta;
                    video_clock = video_clock + delta;
                end
                audio_clock = video_clock - $urandom_range(200);
                queue_frame(OP_VIDEO, video_clock);
            end else if (r < 15) begin
                delta = $urandom_range(20000, 1000);
                if ($urandom_range(1))
                    delta = -delta;
                queue_frame(OP_AUDIO, video_clock + delta);
            end else if (r < 19) begin
                video_clock = video_clock + $urandom_range(70000, 500);
                queue_frame(OP_VIDEO, video_clock);
            end else begin
                // Audio drops out now and then, so video pulls ahead and fillers appear.
                if (audio_muted ? ($urandom_range(99) < 3) : ($urandom_range(99) < 6))
                    audio_muted = !audio_muted;
                if (!audio_muted && audio_clock <= video_clock) begin
                    queue_frame(OP_AUDIO, audio_clock);
                    audio_clock = audio_clock + $urandom_range(23, 20);
                end else begin
                    queue_frame(OP_VIDEO, video_clock);
                    video_clock = video_clock + $urandom_range(40, 33);
                    if (audio_muted)
                        audio_clock = video_clock;
                end
            end
        end
    endtask

    // Waits until every queued frame is taken and every result has come out.
    task automatic drain();
        while (frames_taken != frames_queued || stamps_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Registers are only written while the aligner is idle, one per cycle.
    task automatic configure(input logic [15:0] window, input logic [15:0] jump,
                             input logic [15:0] fill);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_AUDIO_WINDOW;
        i_cfg_data <= window;
        cfg_window = window;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_VIDEO_JUMP_LIMIT;
        i_cfg_data <= jump;
        cfg_jump = jump;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_FILL_DELAY;
        i_cfg_data <= fill;
        cfg_fill = fill;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        reset_aligner_copy();
        video_clock = 64'sd40000;
        audio_clock = 64'sd40000;
        audio_muted = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration, no idling. Audio before any video aligns against
        // the reset value of the used video time and is never dropped.
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_frame(OP_AUDIO, 64'd0);
        queue_frame(OP_AUDIO, 64'd5000);
        queue_frame(OP_VIDEO, 64'd100);
        // Audio older than the filler time is still forwarded.
        queue_frame(OP_AUDIO, 64'd200);
        queue_frame(OP_VIDEO, 64'd6000);
        // Video far ahead of audio: a full run of eight fillers.
        queue_frame(OP_VIDEO, 64'd9000);
        // A video step over the jump limit rebases, then audio re-derives its offset.
        queue_frame(OP_VIDEO, 64'd30000);
        queue_frame(OP_AUDIO, 64'd30000);
        // Extremes of the stamp, including steps whose size is exactly 2^63.
        queue_frame(OP_AUDIO, 64'h7fff_ffff_ffff_ffff);
        queue_frame(OP_AUDIO, 64'h8000_0000_0000_0000);
        queue_frame(OP_VIDEO, 64'h8000_0000_0000_0000);
        queue_frame(OP_VIDEO, 64'h0000_0000_0000_0000);
        queue_frame(OP_VIDEO, 64'hffff_ffff_ffff_ffff);
        queue_frame(OP_AUDIO, 64'hffff_ffff_ffff_ffff);
        queue_frame(OP_VIDEO, 64'h7fff_ffff_ffff_ffff);
        queue_frame(OP_AUDIO, 64'h0000_0000_0000_0000);
        queue_frame(OP_VIDEO, 64'h5555_5555_5555_5555);
        queue_frame(OP_AUDIO, 64'haaaa_aaaa_aaaa_aaaa);
        queue_stream(32);
        drain();

        // Widest settings; the sender is mostly idle.
        configure(16'hffff, 16'hffff, 16'hffff);
        send_idle_pct = 76;
        queue_stream(32);
        drain();

        // Every video change rebases and audio tracking is frozen by a zero fill
        // delay; the receiver stalls most of the time.
        configure(16'd1500, 16'd0, 16'd0);
        send_idle_pct = 0;
        stall_pct     = 76;
        queue_frame(OP_AUDIO, video_clock);
        queue_frame(OP_VIDEO, video_clock + 64'd500);
        queue_stream(32);
        drain();

        // Zero window drops nearly all audio; both sides idle at random.
        configure(16'd0, 16'd4000, 16'd300);
        send_idle_pct = 30;
        stall_pct     = 30;
        queue_stream(32);
        drain();

        // Back to the usual settings with a clean, idle-free stretch.
        configure(16'd3000, 16'd10000, 16'd2000);
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_stream(32);
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Far beyond the slowest legal run: every frame fanning out to nine results
    // through a receiver that stalls 76 percent of the time.
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
